>>> hw/rtl/spa_pkg.sv
package spa_pkg;

  localparam int SLOTS = 64;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int ACT_W = 9;

  // link: top bit set means no slot
  typedef logic [IDX_W:0] link_t;

  localparam link_t NONE_LINK = {1'b1, {IDX_W{1'b0}}};

  localparam logic [2:0] F_ALLOC   = 3'd0;
  localparam logic [2:0] F_RELEASE = 3'd1;
  localparam logic [2:0] F_ENSURE  = 3'd2;
  localparam logic [2:0] F_RESERVE = 3'd3;
  localparam logic [2:0] F_CLEAR   = 3'd4;

  localparam logic [8:0] NONE_S9 = 9'h1FF;

  function automatic logic [8:0] link_to_s9(input link_t l);
    logic [8:0] r;
    r = 9'(l[IDX_W-1:0]);
    if (l[IDX_W]) begin
      r = NONE_S9;
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/spa_ram.sv
module spa_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/slot_pool_with_active_list.sv
// Flow: S_DECIDE, then S_READ for release and for allocate from the free list, then S_W1
// and S_W2 for the list update (S_W2 skipped when appending to an empty list), then S_OUT;
// reserve, clear, failures and ensure of an active slot go from S_DECIDE to S_OUT.
// One operation at a time; a new input is taken only after the result is registered in
// S_OUT, which waits while a stalled result is still held in the output register.
// Reset (rst) empties both lists and clears all active flags at once; link memories
// hold no reset and are only read at entries written since.
module slot_pool_with_active_list (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] func,
  input  logic [7:0] slot_index,
  input  logic [8:0] reserve_count,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       status,
  output logic [8:0] result_slot,
  output logic [8:0] active_total,
  output logic [8:0] used_total,
  output logic [8:0] first_active,
  output logic [8:0] last_active
);

  localparam int IW = spa_pkg::IDX_W;
  localparam int CW = spa_pkg::CNT_W;
  localparam int AW = spa_pkg::ACT_W;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECIDE = 6'b000010,
    S_READ   = 6'b000100,
    S_W1     = 6'b001000,
    S_W2     = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  state_t state;

  // latched operation
  logic [2:0]  func_q;
  logic [7:0]  sidx_q;
  logic [8:0]  scnt_q;

  // list state
  spa_pkg::link_t head, tail, free_top;
  logic [CW-1:0]  used;
  logic [AW-1:0]  active;
  logic [spa_pkg::SLOTS-1:0] flags;

  // working registers
  logic [IW-1:0]  idx;
  spa_pkg::link_t p_q, n_q, res_q;
  logic           st_q;

  // link memories
  logic           prev_we, next_we;
  logic [IW-1:0]  prev_wa, next_wa, next_ra;
  spa_pkg::link_t prev_wd, next_wd, prev_rd, next_rd;

  logic           is_rel;
  logic [8:0]     sidx_ext, ens_cnt;
  logic           sidx_ok;

  assign is_rel   = (func_q == spa_pkg::F_RELEASE);
  assign sidx_ext = {1'b0, sidx_q};
  assign sidx_ok  = (sidx_ext < 9'(spa_pkg::SLOTS));
  assign ens_cnt  = sidx_ext + 9'd1;
  assign in_stall = (state != S_IDLE);

  // allocate reads the free-list successor, release reads the slot's links
  assign next_ra = (func_q == spa_pkg::F_ALLOC) ? free_top[IW-1:0] : sidx_q[IW-1:0];

  spa_ram #(.W(IW + 1), .D(spa_pkg::SLOTS)) u_prev (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_wa),
    .wdata (prev_wd),
    .raddr (sidx_q[IW-1:0]),
    .rdata (prev_rd)
  );

  spa_ram #(.W(IW + 1), .D(spa_pkg::SLOTS)) u_next (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_wa),
    .wdata (next_wd),
    .raddr (next_ra),
    .rdata (next_rd)
  );

  // Write ports. Order of writes follows the list update order, so
  // corrupted lists (ensured slots still on the free list) behave identically.
  always_comb begin
    prev_we = 1'b0;
    prev_wa = idx;
    prev_wd = spa_pkg::NONE_LINK;
    next_we = 1'b0;
    next_wa = idx;
    next_wd = spa_pkg::NONE_LINK;
    case (state)
      S_W1: begin
        if (is_rel) begin
          next_we = !p_q[IW];
          next_wa = p_q[IW-1:0];
          next_wd = n_q;
          prev_we = !n_q[IW];
          prev_wa = n_q[IW-1:0];
          prev_wd = p_q;
        end else begin
          // append: new tail entry
          prev_we = 1'b1;
          prev_wd = tail;
          next_we = 1'b1;
        end
      end
      S_W2: begin
        if (is_rel) begin
          prev_we = 1'b1;
          next_we = 1'b1;
          next_wd = free_top;
        end else begin
          next_we = 1'b1;
          next_wa = tail[IW-1:0];
          next_wd = {1'b0, idx};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      head      <= spa_pkg::NONE_LINK;
      tail      <= spa_pkg::NONE_LINK;
      free_top  <= spa_pkg::NONE_LINK;
      used      <= '0;
      active    <= '0;
      flags     <= '0;
    end else begin
      // result taken; S_OUT reloads the register itself
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            func_q <= func;
            sidx_q <= slot_index;
            scnt_q <= reserve_count;
            state  <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          case (func_q)
            spa_pkg::F_ALLOC: begin
              if (!free_top[IW]) begin
                idx   <= free_top[IW-1:0];
                res_q <= free_top;
                st_q  <= 1'b0;
                state <= S_READ;
              end else if (9'(used) < 9'(spa_pkg::SLOTS)) begin
                idx   <= used[IW-1:0];
                res_q <= {1'b0, used[IW-1:0]};
                used  <= used + CW'(1);
                st_q  <= 1'b0;
                state <= S_W1;
              end else begin
                res_q <= spa_pkg::NONE_LINK;
                st_q  <= 1'b1;
                state <= S_OUT;
              end
            end
            spa_pkg::F_RELEASE: begin
              idx   <= sidx_q[IW-1:0];
              res_q <= spa_pkg::NONE_LINK;
              if (sidx_ext >= 9'(used) || !sidx_ok || !flags[sidx_q[IW-1:0]]) begin
                st_q  <= 1'b1;
                state <= S_OUT;
              end else begin
                st_q  <= 1'b0;
                state <= S_READ;
              end
            end
            spa_pkg::F_ENSURE: begin
              idx   <= sidx_q[IW-1:0];
              res_q <= spa_pkg::NONE_LINK;
              if (!sidx_ok) begin
                st_q  <= 1'b1;
                state <= S_OUT;
              end else begin
                st_q <= 1'b0;
                if (ens_cnt > 9'(used)) begin
                  used <= ens_cnt[CW-1:0];
                end
                state <= flags[sidx_q[IW-1:0]] ? S_OUT : S_W1;
              end
            end
            spa_pkg::F_RESERVE: begin
              res_q <= spa_pkg::NONE_LINK;
              state <= S_OUT;
              if (scnt_q > 9'(spa_pkg::SLOTS)) begin
                st_q <= 1'b1;
              end else begin
                st_q <= 1'b0;
                if (scnt_q > 9'(used)) begin
                  used <= scnt_q[CW-1:0];
                end
              end
            end
            spa_pkg::F_CLEAR: begin
              res_q    <= spa_pkg::NONE_LINK;
              st_q     <= 1'b0;
              state    <= S_OUT;
              head     <= spa_pkg::NONE_LINK;
              tail     <= spa_pkg::NONE_LINK;
              free_top <= spa_pkg::NONE_LINK;
              used     <= '0;
              active   <= '0;
              flags    <= '0;
            end
            default: begin
              res_q <= spa_pkg::NONE_LINK;
              st_q  <= 1'b1;
              state <= S_OUT;
            end
          endcase
        end
        S_READ: begin
          if (is_rel) begin
            p_q <= prev_rd;
            n_q <= next_rd;
          end else begin
            free_top <= next_rd;
          end
          state <= S_W1;
        end
        S_W1: begin
          if (is_rel) begin
            if (p_q[IW]) begin
              head <= n_q;
            end
            if (n_q[IW]) begin
              tail <= p_q;
            end
            state <= S_W2;
          end else begin
            flags[idx] <= 1'b1;
            if (active != '1) begin
              active <= active + AW'(1);
            end
            if (tail[IW]) begin
              head  <= {1'b0, idx};
              tail  <= {1'b0, idx};
              state <= S_OUT;
            end else begin
              state <= S_W2;
            end
          end
        end
        S_W2: begin
          if (is_rel) begin
            flags[idx] <= 1'b0;
            free_top   <= {1'b0, idx};
            if (active != '0) begin
              active <= active - AW'(1);
            end
          end else begin
            tail <= {1'b0, idx};
          end
          state <= S_OUT;
        end
        S_OUT: begin
          // output register frees as soon as the previous result is taken
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            status       <= st_q;
            result_slot  <= spa_pkg::link_to_s9(res_q);
            active_total <= active;
            used_total   <= 9'(used);
            first_active <= spa_pkg::link_to_s9(head);
            last_active  <= spa_pkg::link_to_s9(tail);
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/spa_checker.sv
module spa_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       status,
  input logic [8:0] result_slot,
  input logic [8:0] active_total,
  input logic [8:0] used_total
);

  // one operation in flight
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_slot) && $stable(status))
    else $error("stalled result changed");

  a_used: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> used_total <= 9'(spa_pkg::SLOTS))
    else $error("used count beyond pool");

  a_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_slot != spa_pkg::NONE_S9 |->
      status == 1'b0 && result_slot < 9'(spa_pkg::SLOTS) && active_total != 9'd0)
    else $error("bad allocated slot");

endmodule

bind slot_pool_with_active_list spa_checker u_chk (.*);
